// File: rtl/oah_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hash table package
// Shared widths, operation codes and the command and status bundles that
// pass between the hash table controller and its datapath.
// ----------------------------------------------------------------------------
package oah_pkg;

	// Fixed field widths of the item and result channels.
	localparam int KEY_W  = 31;
	localparam int SLOT_W = 10;
	localparam int CNT_W  = 11;

	// Default number of table slots (a power of two).
	localparam int DEF_TABLE_SLOTS = 1024;

	// Operation codes carried by an input beat.
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Which result the datapath loads into the output register.
	typedef enum logic [2:0] {
		RES_HIT   = 3'd0,
		RES_MISS  = 3'd1,
		RES_FULL  = 3'd2,
		RES_CLEAR = 3'd3,
		RES_NONE  = 3'd4
	} res_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     accept;
		logic     rd;
		logic     adv;
		logic     wr_key;
		logic     clr_wr;
		logic     out_load;
		res_sel_t res_sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic empty;
		logic match;
		logic last;
		logic sweep_last;
		logic out_free;
	} sts_t;

endpackage : oah_pkg
`default_nettype wire

// File: rtl/open_addressing_hash_table.sv
`default_nettype none
// Insert and search read and then check one slot per probe, starting at the home
//   slot, for up to TABLE_SLOTS probes when the table is full.
// Clear sweeps every slot and then gives its result; an unused operation code goes straight to the result.
// One item at a time: a new item is taken only between operations, but it is
//   taken while the last result waits.
// Reset: a sweep empties every slot before the first item.
// ----------------------------------------------------------------------------
// Open addressing hash table
// Insert, search and clear over a power-of-two slot memory with linear or
// double-hash probing, built as a controller and a datapath.
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
	parameter int TABLE_SLOTS = oah_pkg::DEF_TABLE_SLOTS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic                       cfg_wr_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 op,
	input  wire logic [oah_pkg::KEY_W-1:0]  key,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            success,
	output logic [oah_pkg::SLOT_W-1:0]      slot,
	output logic [oah_pkg::CNT_W-1:0]       probe_count
);
	import oah_pkg::*;

	cmd_t cmd;
	sts_t sts;
	op_t  in_op;

	assign in_op = op_t'(op);

	// Sequencer.
	oah_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_op),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Slot memory, probe arithmetic and result stage.
	oah_dp #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_op       (in_op),
		.in_key      (key),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_success (success),
		.out_slot    (slot),
		.out_count   (probe_count)
	);

endmodule : open_addressing_hash_table
`default_nettype wire

// File: rtl/oah_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hash table controller
// State machine that sequences the reset sweep, the probe loop (one read
// and one check per probe), the clear sweep and the result hand-off.
// ----------------------------------------------------------------------------
module oah_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire oah_pkg::op_t  in_op,
	output logic               in_stall,
	input  wire oah_pkg::sts_t sts,
	output oah_pkg::cmd_t      cmd
);
	import oah_pkg::*;

	typedef enum logic [5:0] {
		ST_INIT  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_CHECK = 6'b001000,
		ST_CLEAR = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// New items are taken only between operations.
	assign in_stall = (state_q != ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.res_sel = RES_NONE;
		unique case (state_q)
			ST_INIT: begin
				cmd.clr_wr = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (in_op) inside
						OP_INSERT, OP_SEARCH: state_d = ST_READ;
						OP_CLEAR:             state_d = ST_CLEAR;
						default:              state_d = ST_RESP;
					endcase
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.empty) begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						cmd.wr_key   = (sts.op == OP_INSERT);
						cmd.res_sel  = (sts.op == OP_INSERT) ? RES_HIT : RES_MISS;
						state_d      = ST_IDLE;
					end
				end else if (sts.op == OP_SEARCH && sts.match) begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						cmd.res_sel  = RES_HIT;
						state_d      = ST_IDLE;
					end
				end else if (sts.last) begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						cmd.res_sel  = RES_FULL;
						state_d      = ST_IDLE;
					end
				end else begin
					cmd.adv = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.res_sel  = (sts.op == OP_CLEAR) ? RES_CLEAR : RES_NONE;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

endmodule : oah_ctrl
`default_nettype wire

// File: rtl/oah_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hash table datapath
// Slot memory (valid bit and key per entry), probe position and count,
// probe mode register and the registered result stage.
// ----------------------------------------------------------------------------
module oah_dp #(
	parameter int TABLE_SLOTS = oah_pkg::DEF_TABLE_SLOTS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire oah_pkg::op_t               in_op,
	input  wire logic [oah_pkg::KEY_W-1:0]  in_key,
	input  wire logic                       cfg_wr_en,
	input  wire logic                       cfg_wr_data,
	input  wire oah_pkg::cmd_t              cmd,
	output oah_pkg::sts_t                   sts,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            out_success,
	output logic [oah_pkg::SLOT_W-1:0]      out_slot,
	output logic [oah_pkg::CNT_W-1:0]       out_count
);
	import oah_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_SLOTS);
	localparam int STEP_W = IDX_W - 1;
	localparam int ENT_W  = KEY_W + 1;

	logic [ENT_W-1:0] mem [TABLE_SLOTS];
	logic [ENT_W-1:0] rd_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] step_q;
	logic [IDX_W-1:0] cnt_q;
	logic [KEY_W-1:0] key_q;
	op_t              op_q;
	logic             mode_q;
	logic             out_valid_q;
	logic             success_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;

	logic [IDX_W-1:0] home;
	logic [IDX_W-1:0] dbl_step;
	logic [IDX_W:0]   probes;
	logic             mem_we;
	logic [ENT_W-1:0] mem_wdata;

	// Home slot and odd double-hash step from the incoming key.
	assign home     = IDX_W'(in_key);
	assign dbl_step = {STEP_W'(in_key >> IDX_W), 1'b1};
	assign probes   = {1'b0, cnt_q} + (IDX_W+1)'(1);

	// Probe mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// Operation and key of the item in progress.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= in_op;
			key_q  <= in_key;
			step_q <= mode_q ? dbl_step : IDX_W'(1);
		end
	end

	// Probe position doubles as the sweep index; it starts at zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.accept) begin
			pos_q <= (in_op == OP_CLEAR) ? '0 : home;
		end else if (cmd.adv) begin
			pos_q <= pos_q + step_q;
		end else if (cmd.clr_wr) begin
			pos_q <= pos_q + IDX_W'(1);
		end
	end

	// Probe counter.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cnt_q <= '0;
		end else if (cmd.adv) begin
			cnt_q <= cnt_q + IDX_W'(1);
		end
	end

	// Slot memory: one write port, one registered read port.
	assign mem_we    = cmd.wr_key | cmd.clr_wr;
	assign mem_wdata = cmd.wr_key ? {1'b1, key_q} : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[pos_q] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem[pos_q];
		end
	end

	// Status toward the controller.
	assign sts.op         = op_q;
	assign sts.empty      = ~rd_q[KEY_W];
	assign sts.match      = (rd_q[KEY_W-1:0] == key_q);
	assign sts.last       = &cnt_q;
	assign sts.sweep_last = &pos_q;
	assign sts.out_free   = ~out_valid_q | ~out_stall;

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.res_sel)
				RES_HIT: begin
					success_q <= 1'b1;
					slot_q    <= SLOT_W'(pos_q);
					count_q   <= CNT_W'(probes);
				end
				RES_MISS: begin
					success_q <= 1'b0;
					slot_q    <= '0;
					count_q   <= CNT_W'(probes);
				end
				RES_FULL: begin
					success_q <= 1'b0;
					slot_q    <= '0;
					count_q   <= CNT_W'({1'b1, IDX_W'(0)});
				end
				RES_CLEAR: begin
					success_q <= 1'b1;
					slot_q    <= '0;
					count_q   <= '0;
				end
				default: begin
					success_q <= 1'b0;
					slot_q    <= '0;
					count_q   <= '0;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_success = success_q;
	assign out_slot    = slot_q;
	assign out_count   = count_q;

	// A result is never loaded over one that is still held by the receiver.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a stalled beat");

	// A key is written only into a slot that was read as empty.
	a_write_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_key |-> !rd_q[KEY_W])
		else $error("key written over an occupied slot");

	// The probe loop never advances past the last permitted probe.
	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.adv |-> !(&cnt_q))
		else $error("probe count wrapped");

	// The memory sees at most one of a read, a key write and a clear write at a time.
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.rd, cmd.wr_key, cmd.clr_wr}))
		else $error("memory port used twice in one cycle");

endmodule : oah_dp
`default_nettype wire
